// ===== design/gdc_pkg.sv =====
package gdc_pkg;

  // Datapath operations issued by the controller
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_LOAD       = 5'd1;
  localparam logic [4:0] OP_SQ_X       = 5'd2;
  localparam logic [4:0] OP_SQ_Y       = 5'd3;
  localparam logic [4:0] OP_SQ_DZ      = 5'd4;
  localparam logic [4:0] OP_ZERO_STICK = 5'd5;
  localparam logic [4:0] OP_SQRT_INIT  = 5'd6;
  localparam logic [4:0] OP_SQRT_STEP  = 5'd7;
  localparam logic [4:0] OP_MUL_DEN    = 5'd8;
  localparam logic [4:0] OP_LOAD_DEN   = 5'd9;
  localparam logic [4:0] OP_MUL_NUM    = 5'd10;
  localparam logic [4:0] OP_TRIG       = 5'd11;
  localparam logic [4:0] OP_TRIG_ZERO  = 5'd12;
  localparam logic [4:0] OP_DIV_INIT   = 5'd13;
  localparam logic [4:0] OP_DIV_STEP   = 5'd14;
  localparam logic [4:0] OP_STORE      = 5'd15;
  localparam logic [4:0] OP_FINISH     = 5'd16;

  // Configuration register indexes
  localparam logic REG_STICK_DZ = 1'b0;
  localparam logic REG_TRIG_DZ  = 1'b1;

  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = 17;
  localparam logic [16:0] ONE_Q15 = 17'd32768;

  typedef struct packed {
    logic [4:0] op;
    logic       stick;   // which stick
    logic       coord;   // 0 = x, 1 = y
    logic       trig;    // which trigger
    logic       phase;   // 1 = store goes to a trigger
  } cmd_t;

  typedef struct packed {
    logic below;       // magnitude squared under deadzone squared
    logic m_zero;      // square root came out zero
    logic trig_below;  // trigger under its deadzone
    logic out_busy;    // result register still waiting
  } status_t;

endpackage

// ===== design/gdc_ctrl.sv =====
module gdc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  gdc_pkg::status_t stat,
  output gdc_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_SQDZ  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_MDEN  = 4'd6;
  localparam logic [3:0] S_LDEN  = 4'd7;
  localparam logic [3:0] S_MNUM  = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_STORE = 4'd11;
  localparam logic [3:0] S_TRG   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       s, s_next, c, c_next, k, k_next, ph, ph_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    s_next     = s;
    c_next     = c;
    k_next     = k;
    ph_next    = ph;
    cmd.op     = gdc_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = gdc_pkg::OP_LOAD;
          s_next     = 1'b0;
          ph_next    = 1'b0;
          state_next = S_SQX;
        end
      end
      S_SQX: begin
        cmd.op     = gdc_pkg::OP_SQ_X;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = gdc_pkg::OP_SQ_Y;
        state_next = S_SQDZ;
      end
      S_SQDZ: begin
        cmd.op     = gdc_pkg::OP_SQ_DZ;
        state_next = S_CMP;
      end
      S_CMP: begin
        cnt_next = '0;
        if (stat.below) begin
          cmd.op = gdc_pkg::OP_ZERO_STICK;
          if (!s) begin
            s_next     = 1'b1;
            state_next = S_SQX;
          end else begin
            k_next     = 1'b0;
            ph_next    = 1'b1;
            state_next = S_TRG;
          end
        end else begin
          cmd.op     = gdc_pkg::OP_SQRT_INIT;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op   = gdc_pkg::OP_SQRT_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(gdc_pkg::SQRT_STEPS - 1)) begin
          state_next = S_MDEN;
        end
      end
      S_MDEN: begin
        if (stat.m_zero) begin
          cmd.op = gdc_pkg::OP_ZERO_STICK;
          if (!s) begin
            s_next     = 1'b1;
            state_next = S_SQX;
          end else begin
            k_next     = 1'b0;
            ph_next    = 1'b1;
            state_next = S_TRG;
          end
        end else begin
          cmd.op     = gdc_pkg::OP_MUL_DEN;
          state_next = S_LDEN;
        end
      end
      S_LDEN: begin
        cmd.op     = gdc_pkg::OP_LOAD_DEN;
        c_next     = 1'b0;
        state_next = S_MNUM;
      end
      S_MNUM: begin
        cmd.op     = gdc_pkg::OP_MUL_NUM;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.op     = gdc_pkg::OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op   = gdc_pkg::OP_DIV_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(gdc_pkg::DIV_STEPS - 1)) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.op = gdc_pkg::OP_STORE;
        if (ph) begin
          if (!k) begin
            k_next     = 1'b1;
            state_next = S_TRG;
          end else begin
            state_next = S_FIN;
          end
        end else if (!c) begin
          c_next     = 1'b1;
          state_next = S_MNUM;
        end else if (!s) begin
          s_next     = 1'b1;
          state_next = S_SQX;
        end else begin
          k_next     = 1'b0;
          ph_next    = 1'b1;
          state_next = S_TRG;
        end
      end
      S_TRG: begin
        if (stat.trig_below) begin
          cmd.op = gdc_pkg::OP_TRIG_ZERO;
          if (!k) begin
            k_next = 1'b1;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          cmd.op     = gdc_pkg::OP_TRIG;
          state_next = S_DINIT;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.op     = gdc_pkg::OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.stick = s;
    cmd.coord = c;
    cmd.trig  = k;
    cmd.phase = ph;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      s     <= 1'b0;
      c     <= 1'b0;
      k     <= 1'b0;
      ph    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      s     <= s_next;
      c     <= c_next;
      k     <= k_next;
      ph    <= ph_next;
    end
  end

endmodule

// ===== design/gdc_datapath.sv =====
module gdc_datapath #(
  parameter int BUTTON_COUNT = 26
) (
  input  logic                     clk,
  input  logic                     rst,
  input  gdc_pkg::cmd_t            cmd,
  output gdc_pkg::status_t         stat,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [14:0]              cfg_data,
  input  logic signed [15:0]       left_x,
  input  logic signed [15:0]       left_y,
  input  logic signed [15:0]       right_x,
  input  logic signed [15:0]       right_y,
  input  logic [14:0]              left_trigger,
  input  logic [14:0]              right_trigger,
  input  logic [BUTTON_COUNT-1:0]  button_bits,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [16:0]       left_x_out,
  output logic signed [16:0]       left_y_out,
  output logic signed [16:0]       right_x_out,
  output logic signed [16:0]       right_y_out,
  output logic [15:0]              left_trigger_out,
  output logic [15:0]              right_trigger_out,
  output logic [BUTTON_COUNT-1:0]  buttons_held,
  output logic [BUTTON_COUNT-1:0]  buttons_rose,
  output logic [BUTTON_COUNT-1:0]  buttons_fell,
  output logic [9:0]               axes_active,
  output logic [9:0]               axes_rose,
  output logic [9:0]               axes_fell
);

  function automatic logic signed [16:0] norm_stick(input logic signed [15:0] r);
    // positive side scaled by 32768/32767: adds one from 16384 up
    if (r[15]) begin
      norm_stick = {r[15], r};
    end else begin
      norm_stick = $signed({1'b0, r} + {16'd0, r[14]});
    end
  endfunction

  function automatic logic [15:0] norm_trig(input logic [14:0] r);
    norm_trig = {1'b0, r} + {15'd0, r[14]};
  endfunction

  function automatic logic [16:0] mag17(input logic signed [16:0] v);
    mag17 = v[16] ? 17'(-v) : 17'(v);
  endfunction

  logic [14:0] stick_dz, trig_dz;
  logic [BUTTON_COUNT-1:0] prev_btn, btn_cur;
  logic [9:0]  prev_axes;

  logic signed [16:0] nx [0:3];
  logic [15:0] nt [0:1];
  logic signed [16:0] ws [0:3];
  logic [15:0] wt [0:1];

  logic [31:0] q;
  logic [33:0] prod;
  logic [31:0] sv, sres, sbit;
  logic [15:0] m;
  logic [30:0] den, drem;
  logic [16:0] dlow, dquo;
  logic        dsat;

  logic signed [16:0] sel_x, sel_y, sel_n;
  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_p;
  logic [31:0] sq_t;
  logic        sq_ge;
  logic [46:0] dnum;
  logic [31:0] dr2, ddiff;
  logic        dge;
  logic [16:0] qsat;
  logic [9:0]  axes;
  logic [1:0]  sidx;

  assign sel_x = nx[{cmd.stick, 1'b0}];
  assign sel_y = nx[{cmd.stick, 1'b1}];
  assign sidx  = {cmd.stick, cmd.coord};
  assign sel_n = nx[sidx];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      gdc_pkg::OP_SQ_X: begin
        mul_a = mag17(sel_x);
        mul_b = mag17(sel_x);
      end
      gdc_pkg::OP_SQ_Y: begin
        mul_a = mag17(sel_y);
        mul_b = mag17(sel_y);
      end
      gdc_pkg::OP_SQ_DZ: begin
        mul_a = {2'b0, stick_dz};
        mul_b = {2'b0, stick_dz};
      end
      gdc_pkg::OP_MUL_DEN: begin
        mul_a = gdc_pkg::ONE_Q15 - {2'b0, stick_dz};
        mul_b = {1'b0, sres[15:0]};
      end
      gdc_pkg::OP_MUL_NUM: begin
        mul_a = mag17(sel_n);
        mul_b = {1'b0, m - {1'b0, stick_dz}};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Square root step
  assign sq_t  = sres + sbit;
  assign sq_ge = (sv >= sq_t);

  // Divider: dividend is num * 32768 plus half the divisor
  assign dnum  = {prod[31:0], 15'd0} + {17'd0, den[30:1]};
  assign dr2   = {drem, dlow[16]};
  assign dge   = (dr2 >= {1'b0, den});
  assign ddiff = dr2 - {1'b0, den};
  assign qsat  = (dsat || (dquo > gdc_pkg::ONE_Q15)) ? gdc_pkg::ONE_Q15 : dquo;

  // Status back to the controller
  assign stat.below      = (q < prod[31:0]);
  assign stat.m_zero     = (sres[15:0] == 16'd0);
  assign stat.trig_below = (nt[cmd.trig] < {1'b0, trig_dz});
  assign stat.out_busy   = out_valid && out_stall;

  // Direction bits from the conditioned values
  assign axes = {(wt[1] != 16'd0), (wt[0] != 16'd0),
                 (!ws[3][16] && (ws[3] != 17'sd0)), ws[3][16],
                 (!ws[2][16] && (ws[2] != 17'sd0)), ws[2][16],
                 (!ws[1][16] && (ws[1] != 17'sd0)), ws[1][16],
                 (!ws[0][16] && (ws[0] != 17'sd0)), ws[0][16]};

  // Control state: registers, edge history, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      stick_dz  <= '0;
      trig_dz   <= '0;
      prev_btn  <= '0;
      prev_axes <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gdc_pkg::REG_STICK_DZ: stick_dz <= cfg_data;
          gdc_pkg::REG_TRIG_DZ:  trig_dz  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.op == gdc_pkg::OP_FINISH) begin
        prev_btn  <= btn_cur;
        prev_axes <= axes;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    case (cmd.op)
      gdc_pkg::OP_LOAD: begin
        nx[0]   <= norm_stick(left_x);
        nx[1]   <= norm_stick(left_y);
        nx[2]   <= norm_stick(right_x);
        nx[3]   <= norm_stick(right_y);
        nt[0]   <= norm_trig(left_trigger);
        nt[1]   <= norm_trig(right_trigger);
        btn_cur <= button_bits;
      end
      gdc_pkg::OP_SQ_X: begin
        prod <= mul_p;
      end
      gdc_pkg::OP_SQ_Y: begin
        q    <= prod[31:0];
        prod <= mul_p;
      end
      gdc_pkg::OP_SQ_DZ: begin
        q    <= q + prod[31:0];
        prod <= mul_p;
      end
      gdc_pkg::OP_ZERO_STICK: begin
        ws[{cmd.stick, 1'b0}] <= '0;
        ws[{cmd.stick, 1'b1}] <= '0;
      end
      gdc_pkg::OP_SQRT_INIT: begin
        sv   <= q;
        sres <= '0;
        sbit <= 32'h4000_0000;
      end
      gdc_pkg::OP_SQRT_STEP: begin
        if (sq_ge) begin
          sv   <= sv - sq_t;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      gdc_pkg::OP_MUL_DEN: begin
        m    <= sres[15:0];
        prod <= mul_p;
      end
      gdc_pkg::OP_LOAD_DEN: begin
        den <= prod[30:0];
      end
      gdc_pkg::OP_MUL_NUM: begin
        prod <= mul_p;
      end
      gdc_pkg::OP_TRIG: begin
        den  <= {14'd0, gdc_pkg::ONE_Q15 - {2'b0, trig_dz}};
        prod <= {18'd0, nt[cmd.trig] - {1'b0, trig_dz}};
      end
      gdc_pkg::OP_TRIG_ZERO: begin
        wt[cmd.trig] <= '0;
      end
      gdc_pkg::OP_DIV_INIT: begin
        dsat <= ({1'b0, dnum[46:17]} >= den);
        drem <= {1'b0, dnum[46:17]};
        dlow <= dnum[16:0];
        dquo <= '0;
      end
      gdc_pkg::OP_DIV_STEP: begin
        drem <= dge ? ddiff[30:0] : dr2[30:0];
        dlow <= {dlow[15:0], 1'b0};
        dquo <= {dquo[15:0], dge};
      end
      gdc_pkg::OP_STORE: begin
        if (cmd.phase) begin
          wt[cmd.trig] <= qsat[15:0];
        end else begin
          ws[sidx] <= sel_n[16] ? $signed(17'(-qsat)) : $signed(qsat);
        end
      end
      gdc_pkg::OP_FINISH: begin
        left_x_out        <= ws[0];
        left_y_out        <= ws[1];
        right_x_out       <= ws[2];
        right_y_out       <= ws[3];
        left_trigger_out  <= wt[0];
        right_trigger_out <= wt[1];
        buttons_held      <= btn_cur;
        buttons_rose      <= btn_cur & ~prev_btn;
        buttons_fell      <= ~btn_cur & prev_btn;
        axes_active       <= axes;
        axes_rose         <= axes & ~prev_axes;
        axes_fell         <= ~axes & prev_axes;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/gamepad_deadzone_conditioner_core.sv =====
// Gamepad conditioner: one beat in per poll tick, one beat out. Sticks are
// normalized to Q1.15, pass a scaled radial deadzone and saturate at +/-1.0;
// triggers pass a linear deadzone with rescale; held/rose/fell masks come out
// for the buttons and ten directional axes. One tick at a time: the next
// tick is taken only once this one is finished, and less work is done when a
// stick or trigger sits in its deadzone. A shared 16-step square-root unit
// serves each stick and a 17-step divider each stick coordinate and trigger
// in turn. The result register frees the input side, so the next tick is
// worked on while a result waits.
module gamepad_deadzone_conditioner_core #(
  parameter int BUTTON_COUNT = 26
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [15:0]       left_x,
  input  logic signed [15:0]       left_y,
  input  logic signed [15:0]       right_x,
  input  logic signed [15:0]       right_y,
  input  logic [14:0]              left_trigger,
  input  logic [14:0]              right_trigger,
  input  logic [BUTTON_COUNT-1:0]  button_bits,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [16:0]       left_x_out,
  output logic signed [16:0]       left_y_out,
  output logic signed [16:0]       right_x_out,
  output logic signed [16:0]       right_y_out,
  output logic [15:0]              left_trigger_out,
  output logic [15:0]              right_trigger_out,
  output logic [BUTTON_COUNT-1:0]  buttons_held,
  output logic [BUTTON_COUNT-1:0]  buttons_rose,
  output logic [BUTTON_COUNT-1:0]  buttons_fell,
  output logic [9:0]               axes_active,
  output logic [9:0]               axes_rose,
  output logic [9:0]               axes_fell,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [14:0]              cfg_data
);

  gdc_pkg::cmd_t    cmd;
  gdc_pkg::status_t stat;

  gdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  gdc_datapath #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .left_x            (left_x),
    .left_y            (left_y),
    .right_x           (right_x),
    .right_y           (right_y),
    .left_trigger      (left_trigger),
    .right_trigger     (right_trigger),
    .button_bits       (button_bits),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .left_x_out        (left_x_out),
    .left_y_out        (left_y_out),
    .right_x_out       (right_x_out),
    .right_y_out       (right_y_out),
    .left_trigger_out  (left_trigger_out),
    .right_trigger_out (right_trigger_out),
    .buttons_held      (buttons_held),
    .buttons_rose      (buttons_rose),
    .buttons_fell      (buttons_fell),
    .axes_active       (axes_active),
    .axes_rose         (axes_rose),
    .axes_fell         (axes_fell)
  );

endmodule
